>>> rtl/assert_macros.svh
// Assertion macros used by the top level of the bus arbiter.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef ASSERT_OFF

// Property that must hold at every clock edge outside reset.
`define ASSERT_PROP(label, clk, rst, prop) \
   label: assert property (@(posedge clk) disable iff (rst) (prop)) \
      else $error("assertion failed");

// Condition that must never be true outside reset.
`define ASSERT_NEVER(label, clk, rst, cond) \
   label: assert property (@(posedge clk) disable iff (rst) !(cond)) \
      else $error("forbidden condition seen");

`else

`define ASSERT_PROP(label, clk, rst, prop)
`define ASSERT_NEVER(label, clk, rst, cond)

`endif

`endif

>>> rtl/apba_pkg.sv
// Package with widths, codes and types shared by the bus arbiter modules.
`default_nettype none

package apba_pkg;

   // Requester count default and width of the index field
   localparam int NUM_REQ_DEFAULT = 6;
   localparam int REQ_IDX_W       = 3;
   localparam int LEVEL_W         = 8;
   localparam int OP_W            = 2;
   localparam int CSR_IDX_W       = 3;
   localparam int REQ_DATA_W      = 8;
   localparam int RSP_DATA_W      = 8;

   // Level of a requester with nothing pending
   localparam logic [LEVEL_W-1:0] IDLE_LEVEL = 8'hFF;

   // Request operation codes; the unused code acts as a poll
   typedef enum logic [OP_W-1:0] {
      OP_REQUEST = 2'd0,
      OP_RELEASE = 2'd1,
      OP_POLL    = 2'd2
   } op_type;

   // Bus holder as passed between grant logic and the top level
   typedef struct packed {
      logic                 valid;
      logic [REQ_IDX_W-1:0] index;
   } grant_type;

endpackage

`default_nettype wire

>>> rtl/apba_level_update.sv
// Per-requester level update for request and release operations.
`default_nettype none

module apba_level_update #(
   parameter int NUM_REQUESTERS = apba_pkg::NUM_REQ_DEFAULT
) (
   input  wire logic [apba_pkg::OP_W-1:0]                          op,
   input  wire logic [apba_pkg::REQ_IDX_W-1:0]                     who,
   input  wire logic [NUM_REQUESTERS-1:0][apba_pkg::LEVEL_W-1:0]   static_prio,
   input  wire logic [NUM_REQUESTERS-1:0][apba_pkg::LEVEL_W-1:0]   level_cur,
   output logic      [NUM_REQUESTERS-1:0][apba_pkg::LEVEL_W-1:0]   level_next
);
   import apba_pkg::*;

   logic in_range;

   // Requester index inside the populated range
   assign in_range = ({1'b0, who} < (REQ_IDX_W + 1)'(NUM_REQUESTERS));

   // Each entry is updated on its own
   always_comb begin
      for (int i = 0; i < NUM_REQUESTERS; i++) begin
         level_next[i] = level_cur[i];
         unique case (op)
            OP_REQUEST: begin
               if (in_range && (who == REQ_IDX_W'(i)) &&
                   (static_prio[i] < level_cur[i])) begin
                  level_next[i] = static_prio[i];
               end
            end
            OP_RELEASE: begin
               if (in_range) begin
                  if (who == REQ_IDX_W'(i)) begin
                     level_next[i] = IDLE_LEVEL;
                  end else if ((level_cur[i] != IDLE_LEVEL) &&
                               (level_cur[i] != '0)) begin
                     // aging toward zero, saturating
                     level_next[i] = level_cur[i] - LEVEL_W'(1);
                  end
               end
            end
            default: begin
               level_next[i] = level_cur[i];
            end
         endcase
      end
   end

endmodule

`default_nettype wire

>>> rtl/apba_grant_select.sv
// Lowest-level search across requesters, ties to the lowest index.
`default_nettype none

module apba_grant_select #(
   parameter int NUM_REQUESTERS = apba_pkg::NUM_REQ_DEFAULT
) (
   input  wire logic                                              bus_free,
   input  wire logic [NUM_REQUESTERS-1:0][apba_pkg::LEVEL_W-1:0]  level,
   output apba_pkg::grant_type                                    grant
);
   import apba_pkg::*;

   logic [LEVEL_W-1:0]   best;
   logic [REQ_IDX_W-1:0] best_idx;
   logic                 found;

   // Strict less-than keeps the first of equal levels
   always_comb begin
      best     = IDLE_LEVEL;
      best_idx = '0;
      found    = 1'b0;
      for (int i = 0; i < NUM_REQUESTERS; i++) begin
         if (level[i] < best) begin
            best     = level[i];
            best_idx = REQ_IDX_W'(i);
            found    = 1'b1;
         end
      end
   end

   // Only a free bus takes a new holder
   assign grant.valid = bus_free && found;
   assign grant.index = (bus_free && found) ? best_idx : '0;

endmodule

`default_nettype wire

>>> rtl/aging_priority_bus_arbiter.sv
// Top level of the aging priority bus arbiter.
//
//  channel | dir | handshake             | payload
//  --------+-----+-----------------------+-------------------------------------
//  req     | in  | req_tvalid/req_tready | operation, requester
//  rsp     | out | rsp_tvalid/rsp_tready | grant_valid, granted_requester
//  csr     | in  | csr_wen               | static priority per requester
//
//  One request per cycle sustained while results are taken; a result passes
//  through the input register, then the result register, once its request is
//  taken. Level update and the lowest-level search run combinationally
//  between the two registers.
//  Synchronous reset: all levels idle, no holder, static priority i.
//  A stalled result holds the input register; a new request is taken in the
//  same cycle the pending result is taken.
`default_nettype none

`include "assert_macros.svh"

module aging_priority_bus_arbiter #(
   parameter int NUM_REQUESTERS = apba_pkg::NUM_REQ_DEFAULT
) (
   input  wire logic                               clock,
   input  wire logic                               reset,
   // request channel
   input  wire logic                               req_tvalid,
   output logic                                    req_tready,
   input  wire logic [apba_pkg::REQ_DATA_W-1:0]    req_tdata,  // operation[1:0], requester[4:2]
   // result channel
   output logic                                    rsp_tvalid,
   input  wire logic                               rsp_tready,
   output logic      [apba_pkg::RSP_DATA_W-1:0]    rsp_tdata,  // grant_valid[0], granted_requester[3:1]
   // configuration writes
   input  wire logic                               csr_wen,
   input  wire logic [apba_pkg::CSR_IDX_W-1:0]     csr_index,
   input  wire logic [apba_pkg::LEVEL_W-1:0]       csr_wdata
);
   import apba_pkg::*;

   // Input register
   logic                 s1_valid_ff, s1_valid_in;
   logic [OP_W-1:0]      s1_op_ff;
   logic [REQ_IDX_W-1:0] s1_who_ff;

   // Result register
   logic                 out_valid_ff, out_valid_in;
   grant_type            out_grant_ff;

   // Arbiter state
   logic [NUM_REQUESTERS-1:0][LEVEL_W-1:0] level_ff, level_in;
   logic [NUM_REQUESTERS-1:0][LEVEL_W-1:0] static_prio_ff;
   grant_type                              holder_ff, holder_in;

   logic      req_take;
   logic      s1_advance;
   logic      bus_free;
   grant_type new_grant;
   logic [NUM_REQUESTERS-1:0] pending;

   // Handshake control
   assign s1_advance  = s1_valid_ff && (!out_valid_ff || rsp_tready);
   assign req_tready  = !s1_valid_ff || s1_advance;
   assign req_take    = req_tvalid && req_tready;
   assign s1_valid_in = req_take || (s1_valid_ff && !s1_advance);
   assign out_valid_in = s1_advance || (out_valid_ff && !rsp_tready);

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff  <= 1'b0;
         out_valid_ff <= 1'b0;
      end else begin
         s1_valid_ff  <= s1_valid_in;
         out_valid_ff <= out_valid_in;
      end
   end

   // Capture request payload
   always_ff @(posedge clock) begin
      if (req_take) begin
         s1_op_ff  <= req_tdata[OP_W-1:0];
         s1_who_ff <= req_tdata[OP_W +: REQ_IDX_W];
      end
   end

   // Static priority registers
   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < NUM_REQUESTERS; i++) begin
            static_prio_ff[i] <= LEVEL_W'(i);
         end
      end else if (csr_wen) begin
         for (int i = 0; i < NUM_REQUESTERS; i++) begin
            if (csr_index == CSR_IDX_W'(i)) begin
               static_prio_ff[i] <= csr_wdata;
            end
         end
      end
   end

   apba_level_update #(
      .NUM_REQUESTERS (NUM_REQUESTERS)
   ) u_level_update (
      .op          (s1_op_ff),
      .who         (s1_who_ff),
      .static_prio (static_prio_ff),
      .level_cur   (level_ff),
      .level_next  (level_in)
   );

   // Any release frees the bus before the grant is re-run
   assign bus_free = !holder_ff.valid || (s1_op_ff == OP_RELEASE);

   apba_grant_select #(
      .NUM_REQUESTERS (NUM_REQUESTERS)
   ) u_grant_select (
      .bus_free (bus_free),
      .level    (level_in),
      .grant    (new_grant)
   );

   // Keep the holder unless the bus was freed
   assign holder_in = bus_free ? new_grant : holder_ff;

   // State and result update, one request per advance
   always_ff @(posedge clock) begin
      if (reset) begin
         level_ff  <= {NUM_REQUESTERS{IDLE_LEVEL}};
         holder_ff <= '0;
      end else if (s1_advance) begin
         level_ff  <= level_in;
         holder_ff <= holder_in;
      end
   end

   always_ff @(posedge clock) begin
      if (s1_advance) begin
         out_grant_ff <= holder_in;
      end
   end

   assign rsp_tvalid = out_valid_ff;
   assign rsp_tdata  = {(RSP_DATA_W - REQ_IDX_W - 1)'(0),
                        out_grant_ff.index, out_grant_ff.valid};

   // Requesters with a level below idle
   always_comb begin
      for (int i = 0; i < NUM_REQUESTERS; i++) begin
         pending[i] = (level_ff[i] != IDLE_LEVEL);
      end
   end

   // A holder exists exactly when something is pending
   `ASSERT_PROP(a_holder_iff_pending, clock, reset, holder_ff.valid == (pending != '0))
   // Holder index stays within the requester count
   `ASSERT_NEVER(a_holder_in_range, clock, reset, ({1'b0, holder_ff.index} >= (REQ_IDX_W + 1)'(NUM_REQUESTERS)))
   // A shown result always mirrors the current holder
   `ASSERT_PROP(a_rsp_matches_state, clock, reset, out_valid_ff |-> (out_grant_ff == holder_ff))
   // An advancing request always lands in the result register
   `ASSERT_PROP(a_advance_fills_out, clock, reset, s1_advance |=> out_valid_ff)

endmodule

`default_nettype wire

>>> tb/aging_priority_bus_arbiter_test.sv
// Self-checking testbench for the aging priority bus arbiter.
`timescale 1ns / 1ps

module aging_priority_bus_arbiter_test;
   import apba_pkg::*;

   localparam int NUM_REQ         = NUM_REQ_DEFAULT;
   localparam int ITEMS_PER_PHASE = 313;
   localparam int NUM_PHASES      = 6;
   localparam int CYCLE_LIMIT     = 200000;
   localparam int DRAIN_CYCLES    = 4;

   // unused operation code, decoded as a poll
   localparam logic [OP_W-1:0] OP_SPARE = 2'd3;
   // register indexes past the last static priority, writes are dropped
   localparam logic [CSR_IDX_W-1:0] CSR_IDX_SPARE_LO = 3'd6;
   localparam logic [CSR_IDX_W-1:0] CSR_IDX_SPARE_HI = 3'd7;

   logic                  clock      = 1'b0;
   logic                  reset      = 1'b1;
   logic                  req_tvalid = 1'b0;
   logic                  req_tready;
   logic [REQ_DATA_W-1:0] req_tdata  = '0;  // operation[1:0], requester[4:2]
   logic                  rsp_tvalid;
   logic                  rsp_tready = 1'b0;
   logic [RSP_DATA_W-1:0] rsp_tdata;        // grant_valid[0], granted_requester[3:1]
   logic                  csr_wen    = 1'b0;
   logic [CSR_IDX_W-1:0]  csr_index  = '0;
   logic [LEVEL_W-1:0]    csr_wdata  = '0;

   aging_priority_bus_arbiter #(.NUM_REQUESTERS(NUM_REQ)) dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .csr_wen    (csr_wen),
      .csr_index  (csr_index),
      .csr_wdata  (csr_wdata)
   );

   always #10 clock = ~clock;

   // arbiter state as the testbench tracks it
   logic [LEVEL_W-1:0] prio_cfg [NUM_REQ];
   logic [LEVEL_W-1:0] pend_level [NUM_REQ];
   grant_type          bus_owner;
   grant_type          expected_grants [$];

   bit failed = 1'b0;
   int cycle_count = 0;
   int send_idle_pct = 0;
   int recv_idle_pct = 0;

   // directed rows: a request, or a register write when is_cfg is set
   // (who then holds the register index and cfg_data the value)
   typedef struct {
      bit                   is_cfg;
      logic [OP_W-1:0]      op;
      logic [REQ_IDX_W-1:0] who;
      logic [LEVEL_W-1:0]   cfg_data;
      bit                   typed;
      logic                 exp_valid;
      logic [REQ_IDX_W-1:0] exp_index;
   } step_row_type;

   localparam int DIR_ROWS = 24;
   step_row_type dir_tab [DIR_ROWS] = '{
      '{0, OP_POLL,    3'd0, 8'd0,   1, 1'b0, 3'd0},  // poll right after reset
      '{0, OP_SPARE,   3'd5, 8'd0,   1, 1'b0, 3'd0},  // spare code acts as poll
      '{0, OP_RELEASE, 3'd0, 8'd0,   1, 1'b0, 3'd0},  // release with nobody holding
      '{0, OP_REQUEST, 3'd7, 8'd0,   1, 1'b0, 3'd0},  // requester out of range
      '{0, OP_REQUEST, 3'd6, 8'd0,   1, 1'b0, 3'd0},
      '{0, OP_REQUEST, 3'd5, 8'd0,   1, 1'b1, 3'd5},  // first grant
      '{0, OP_REQUEST, 3'd0, 8'd0,   1, 1'b1, 3'd5},  // holder kept despite better level
      '{0, OP_REQUEST, 3'd3, 8'd0,   1, 1'b1, 3'd5},
      '{0, OP_RELEASE, 3'd5, 8'd0,   0, 1'b0, 3'd0},  // aging, level 0 saturates
      '{0, OP_RELEASE, 3'd7, 8'd0,   0, 1'b0, 3'd0},  // out-of-range release frees the bus
      '{0, OP_RELEASE, 3'd0, 8'd0,   0, 1'b0, 3'd0},
      '{0, OP_REQUEST, 3'd1, 8'd0,   0, 1'b0, 3'd0},
      '{0, OP_REQUEST, 3'd3, 8'd0,   0, 1'b0, 3'd0},  // holder requests again
      '{0, OP_RELEASE, 3'd2, 8'd0,   0, 1'b0, 3'd0},  // release by non-holder, tie to index
      '{0, OP_RELEASE, 3'd1, 8'd0,   0, 1'b0, 3'd0},
      '{1, OP_POLL,    3'd2, 8'd255, 0, 1'b0, 3'd0},  // static priority 255
      '{1, OP_POLL,    CSR_IDX_SPARE_HI, 8'd0, 0, 1'b0, 3'd0},
      '{0, OP_REQUEST, 3'd2, 8'd0,   0, 1'b0, 3'd0},  // stays idle
      '{0, OP_RELEASE, 3'd3, 8'd0,   0, 1'b0, 3'd0},
      '{0, OP_REQUEST, 3'd2, 8'd0,   0, 1'b0, 3'd0},
      '{0, OP_REQUEST, 3'd4, 8'd0,   0, 1'b0, 3'd0},
      '{0, OP_POLL,    3'd7, 8'd0,   0, 1'b0, 3'd0},
      '{0, OP_SPARE,   3'd2, 8'd0,   0, 1'b0, 3'd0},
      '{0, OP_RELEASE, 3'd4, 8'd0,   0, 1'b0, 3'd0}
   };

   // Apply one request to the tracked state and return the bus holder after it.
   function automatic grant_type predict_grant(input logic [OP_W-1:0] op,
                                               input logic [REQ_IDX_W-1:0] who);
      logic [LEVEL_W-1:0] best;
      if (op == OP_REQUEST) begin
         if (who < NUM_REQ && prio_cfg[who] < pend_level[who])
            pend_level[who] = prio_cfg[who];
      end else if (op == OP_RELEASE) begin
         if (who < NUM_REQ) begin
            for (int i = 0; i < NUM_REQ; i++) begin
               if (i == who)
                  pend_level[i] = IDLE_LEVEL;
               else if (pend_level[i] != IDLE_LEVEL && pend_level[i] != '0)
                  pend_level[i] = pend_level[i] - 1'b1;
            end
         end
         bus_owner = '0;
      end
      // lowest pending level wins, first index on a tie
      if (!bus_owner.valid) begin
         best = IDLE_LEVEL;
         for (int i = 0; i < NUM_REQ; i++) begin
            if (pend_level[i] < best) begin
               best = pend_level[i];
               bus_owner.index = REQ_IDX_W'(i);
               bus_owner.valid = 1'b1;
            end
         end
      end
      return bus_owner;
   endfunction

   // Queue the expected holder, then hand the request over.
   task automatic send_request(input logic [OP_W-1:0] op, input logic [REQ_IDX_W-1:0] who,
                               input grant_type want);
      csr_wen <= 1'b0;
      expected_grants.push_back(want);
      while ($urandom_range(99) < send_idle_pct) begin
         req_tvalid <= 1'b0;
         @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tdata  <= {{(REQ_DATA_W-OP_W-REQ_IDX_W){1'b0}}, who, op};
      do @(posedge clock); while (!req_tready);
   endtask

   // Register write, only once every outstanding result has come back.
   task automatic write_prio(input logic [CSR_IDX_W-1:0] idx, input logic [LEVEL_W-1:0] value);
      req_tvalid <= 1'b0;
      while (expected_grants.size() != 0) @(posedge clock);
      csr_wen   <= 1'b1;
      csr_index <= idx;
      csr_wdata <= value;
      if (idx < NUM_REQ)
         prio_cfg[idx] = value;
      @(posedge clock);
   endtask

   // Mostly requests and releases by the holder, with some noise.
   task automatic random_request();
      logic [OP_W-1:0]      op;
      logic [REQ_IDX_W-1:0] who;
      int                   pick;
      pick = $urandom_range(99);
      who  = ($urandom_range(19) == 0) ? REQ_IDX_W'($urandom_range(7, NUM_REQ))
                                       : REQ_IDX_W'($urandom_range(NUM_REQ-1));
      if (pick < 45) begin
         op = OP_REQUEST;
      end else if (pick < 80) begin
         op = OP_RELEASE;
         if (bus_owner.valid && $urandom_range(9) < 7)
            who = bus_owner.index;
      end else if (pick < 93) begin
         op  = OP_POLL;
         who = REQ_IDX_W'($urandom_range(7));
      end else begin
         op  = OP_SPARE;
         who = REQ_IDX_W'($urandom_range(7));
      end
      send_request(op, who, predict_grant(op, who));
   endtask

   // Program a full set of static priorities for one phase.
   task automatic apply_settings(input int phase);
      logic [LEVEL_W-1:0] value;
      for (int i = 0; i < NUM_REQ; i++) begin
         case (phase)
            1: value = 8'd0;                                    // all tied at the top
            2: value = (i == 4) ? 8'd0 : (i == 1) ? 8'd254 : 8'd255;
            3: value = LEVEL_W'($urandom_range(7));             // many ties
            4: value = LEVEL_W'($urandom_range(255));
            default: value = LEVEL_W'((NUM_REQ - 1 - i) * 50);  // reversed order
         endcase
         write_prio(CSR_IDX_W'(i), value);
      end
      write_prio(CSR_IDX_SPARE_LO, LEVEL_W'($urandom_range(255)));
      write_prio(CSR_IDX_SPARE_HI, LEVEL_W'($urandom_range(255)));
   endtask

   // Result side: check against the oldest expectation, random backpressure.
   always @(posedge clock) begin
      grant_type got;
      grant_type want;
      if (!reset && rsp_tvalid && rsp_tready) begin
         got.valid = rsp_tdata[0];
         got.index = rsp_tdata[REQ_IDX_W:1];
         if (expected_grants.size() == 0) begin
            $display("%0t: unexpected result grant_valid %0d granted_requester %0d",
                     $time, got.valid, got.index);
            failed = 1'b1;
         end else begin
            want = expected_grants.pop_front();
            if (got.valid !== want.valid) begin
               $display("%0t: grant_valid expected %0d actual %0d",
                        $time, want.valid, got.valid);
               failed = 1'b1;
            end
            if (got.index !== want.index) begin
               $display("%0t: granted_requester expected %0d actual %0d",
                        $time, want.index, got.index);
               failed = 1'b1;
            end
         end
      end
      rsp_tready <= ($urandom_range(99) >= recv_idle_pct);
   end

   // Watchdog
   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count > CYCLE_LIMIT) begin
         $display("Regression FAIL");
         $finish;
      end
   end

   initial begin
      grant_type want;
      for (int i = 0; i < NUM_REQ; i++) begin
         prio_cfg[i]   = LEVEL_W'(i);
         pend_level[i] = IDLE_LEVEL;
      end
      bus_owner = '0;

      repeat (3) @(posedge clock);
      reset <= 1'b0;

      for (int phase = 0; phase < NUM_PHASES; phase++) begin
         // sender lightly idle / receiver heavily stalled, then swapped, then none
         case (phase / 2)
            0: begin send_idle_pct = 8;  recv_idle_pct = 78; end
            1: begin send_idle_pct = 78; recv_idle_pct = 8;  end
            default: begin send_idle_pct = 0; recv_idle_pct = 0; end
         endcase
         if (phase == 0) begin
            for (int r = 0; r < DIR_ROWS; r++) begin
               if (dir_tab[r].is_cfg) begin
                  write_prio(dir_tab[r].who, dir_tab[r].cfg_data);
               end else begin
                  want = predict_grant(dir_tab[r].op, dir_tab[r].who);
                  if (dir_tab[r].typed) begin
                     want.valid = dir_tab[r].exp_valid;
                     want.index = dir_tab[r].exp_index;
                  end
                  send_request(dir_tab[r].op, dir_tab[r].who, want);
               end
            end
         end else begin
            apply_settings(phase);
         end
         repeat (ITEMS_PER_PHASE) random_request();
      end

      req_tvalid <= 1'b0;
      while (expected_grants.size() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
      if (!failed && expected_grants.size() == 0)
         $display("Regression PASS");
      else
         $display("Regression FAIL");
      $finish;
   end

endmodule

>>> aging_priority_bus_arbiter.f
+incdir+rtl
rtl/apba_pkg.sv
rtl/apba_level_update.sv
rtl/apba_grant_select.sv
rtl/aging_priority_bus_arbiter.sv
tb/aging_priority_bus_arbiter_test.sv
